@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, suspended while rst is high.
`define CIR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication, suspended while rst is high.
`define CIR_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/core/cir_pkg.sv @@
// Types and fixed-point constants shared by the collision impulse pipeline.
`timescale 1ns / 1ps

package cir_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    OUTCOME_IMPULSE    = 2'd0,
    OUTCOME_SEPARATING = 2'd1,
    OUTCOME_STATIC     = 2'd2
  } outcome_t;

  // Control that travels with each request down the pipeline.
  typedef struct packed {
    logic     valid;
    outcome_t outcome;
  } ctl_t;

  localparam int NRM_W   = 16;  // normal, Q2.14
  localparam int REST_W  = 17;  // restitution, Q1.16
  localparam int IMASS_W = 32;  // inverse mass, Q16.16
  localparam int SUM_W   = IMASS_W + 1;
  localparam int ONE_E_W = 18;  // holds 1.0 + e, up to 2.0 in Q2.16
  localparam int M_GROW  = 3;   // normal speed magnitude grows 3 bits over the velocity
  localparam int VEL_CAP = 32;  // velocities use at most this many bits

  localparam int FRAC_V  = 16;
  localparam int FRAC_N  = 14;
  localparam int HALF_V  = 1 << (FRAC_V - 1);
  localparam int HALF_N  = 1 << (FRAC_N - 1);

  localparam logic [REST_W-1:0] REST_ONE = REST_W'(1 << FRAC_V);

endpackage

@@ rtl/core/cir_front.sv @@
// Front stages: relative normal speed, impulse numerator and mass-ratio product.
`timescale 1ns / 1ps

module cir_front #(
  parameter int VW = 32,
  localparam int NUM_W = VW + cir_pkg::M_GROW + cir_pkg::ONE_E_W,
  localparam int P_W   = NUM_W + cir_pkg::IMASS_W,
  localparam int PAY_W = 4 * VW + 2 * cir_pkg::NRM_W
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic signed [VW-1:0]              vel_a_x,
  input  logic signed [VW-1:0]              vel_a_y,
  input  logic signed [VW-1:0]              vel_b_x,
  input  logic signed [VW-1:0]              vel_b_y,
  input  logic [cir_pkg::REST_W-1:0]        restitution_a,
  input  logic [cir_pkg::REST_W-1:0]        restitution_b,
  input  logic [cir_pkg::IMASS_W-1:0]       inv_mass_a,
  input  logic [cir_pkg::IMASS_W-1:0]       inv_mass_b,
  input  logic signed [cir_pkg::NRM_W-1:0]  normal_x,
  input  logic signed [cir_pkg::NRM_W-1:0]  normal_y,
  output cir_pkg::ctl_t                     ctl_out,
  output logic [NUM_W-1:0]                  num_out,
  output logic [cir_pkg::SUM_W-1:0]         divisor_out,
  output logic [P_W-1:0]                    dividend_out,
  output logic [PAY_W-1:0]                  pay_out
);
  import cir_pkg::*;

  localparam int RV_W  = VW + 1;
  localparam int PR_W  = RV_W + NRM_W;
  localparam int VN_W  = PR_W + 1;
  localparam int M_W   = VW + M_GROW;
  localparam int LO_W  = NUM_W / 2;
  localparam int HI_W  = NUM_W - LO_W;
  localparam int OFF_NX = NRM_W;

  // stage 1: relative velocity
  logic                     s1_valid;
  logic [PAY_W-1:0]         s1_pay;
  logic signed [RV_W-1:0]   s1_rv_x, s1_rv_y;
  logic [REST_W-1:0]        s1_ea, s1_eb;
  logic [IMASS_W-1:0]       s1_ia, s1_ib;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    s1_pay  <= {vel_a_x, vel_a_y, vel_b_x, vel_b_y, normal_x, normal_y};
    s1_rv_x <= RV_W'(vel_b_x) - RV_W'(vel_a_x);
    s1_rv_y <= RV_W'(vel_b_y) - RV_W'(vel_a_y);
    s1_ea   <= restitution_a;
    s1_eb   <= restitution_b;
    s1_ia   <= inv_mass_a;
    s1_ib   <= inv_mass_b;
  end

  // stage 2: projections on the normal
  logic                     s2_valid;
  logic [PAY_W-1:0]         s2_pay;
  logic signed [PR_W-1:0]   s2_px, s2_py;
  logic [REST_W-1:0]        s2_ea, s2_eb;
  logic [IMASS_W-1:0]       s2_ia, s2_ib;
  logic signed [NRM_W-1:0]  s1_nx, s1_ny;

  assign s1_nx = $signed(s1_pay[OFF_NX +: NRM_W]);
  assign s1_ny = $signed(s1_pay[0 +: NRM_W]);

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else     s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    s2_pay <= s1_pay;
    s2_px  <= s1_rv_x * s1_nx;
    s2_py  <= s1_rv_y * s1_ny;
    s2_ea  <= s1_ea;
    s2_eb  <= s1_eb;
    s2_ia  <= s1_ia;
    s2_ib  <= s1_ib;
  end

  // stage 3: normal speed, restitution factor, mass sum
  logic                     s3_valid;
  logic [PAY_W-1:0]         s3_pay;
  logic signed [VN_W-1:0]   s3_vn;
  logic [ONE_E_W-1:0]       s3_one_e;
  logic [SUM_W-1:0]         s3_sum;
  logic                     s3_static;
  logic [IMASS_W-1:0]       s3_ia;
  logic [REST_W-1:0]        e_min, e_clamp;

  always_comb begin
    e_min   = (s2_ea < s2_eb) ? s2_ea : s2_eb;
    e_clamp = (e_min > REST_ONE) ? REST_ONE : e_min;
  end

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else     s3_valid <= s2_valid;
  end

  always_ff @(posedge clk) begin
    s3_pay    <= s2_pay;
    s3_vn     <= VN_W'(s2_px) + VN_W'(s2_py);
    s3_one_e  <= ONE_E_W'(REST_ONE) + ONE_E_W'(e_clamp);
    s3_sum    <= SUM_W'(s2_ia) + SUM_W'(s2_ib);
    s3_static <= (s2_ia == '0) && (s2_ib == '0);
    s3_ia     <= s2_ia;
  end

  // stage 4: outcome decision, closing speed rounded to Q16.16
  ctl_t                     s4_ctl, s4_ctl_next;
  logic [PAY_W-1:0]         s4_pay;
  logic [M_W-1:0]           s4_m;
  logic [ONE_E_W-1:0]       s4_one_e;
  logic [SUM_W-1:0]         s4_sum;
  logic [IMASS_W-1:0]       s4_ia;
  logic [VN_W-1:0]          m_round;

  always_comb begin
    s4_ctl_next.valid = s3_valid;
    if (s3_vn > 0)      s4_ctl_next.outcome = OUTCOME_SEPARATING;
    else if (s3_static) s4_ctl_next.outcome = OUTCOME_STATIC;
    else                s4_ctl_next.outcome = OUTCOME_IMPULSE;
    // only meaningful when vn <= 0; the other cases ignore it
    m_round = VN_W'(-s3_vn) + VN_W'(HALF_N);
  end

  always_ff @(posedge clk) begin
    if (rst) s4_ctl <= '0;
    else     s4_ctl <= s4_ctl_next;
  end

  always_ff @(posedge clk) begin
    s4_pay   <= s3_pay;
    s4_m     <= M_W'(m_round >> FRAC_N);
    s4_one_e <= s3_one_e;
    s4_sum   <= s3_sum;
    s4_ia    <= s3_ia;
  end

  // stage 5: numerator (1 + e) * m
  ctl_t                     s5_ctl;
  logic [PAY_W-1:0]         s5_pay;
  logic [NUM_W-1:0]         s5_num;
  logic [SUM_W-1:0]         s5_sum;
  logic [IMASS_W-1:0]       s5_ia;

  always_ff @(posedge clk) begin
    if (rst) s5_ctl <= '0;
    else     s5_ctl <= s4_ctl;
  end

  always_ff @(posedge clk) begin
    s5_pay <= s4_pay;
    s5_num <= s4_one_e * s4_m;
    s5_sum <= s4_sum;
    s5_ia  <= s4_ia;
  end

  // stage 6: num * inv_mass_a as two partial products
  ctl_t                     s6_ctl;
  logic [PAY_W-1:0]         s6_pay;
  logic [NUM_W-1:0]         s6_num;
  logic [SUM_W-1:0]         s6_sum;
  logic [LO_W+IMASS_W-1:0]  s6_p_lo;
  logic [HI_W+IMASS_W-1:0]  s6_p_hi;

  always_ff @(posedge clk) begin
    if (rst) s6_ctl <= '0;
    else     s6_ctl <= s5_ctl;
  end

  always_ff @(posedge clk) begin
    s6_pay  <= s5_pay;
    s6_num  <= s5_num;
    s6_sum  <= s5_sum;
    s6_p_lo <= s5_num[LO_W-1:0] * s5_ia;
    s6_p_hi <= s5_num[NUM_W-1:LO_W] * s5_ia;
  end

  // stage 7: partial products summed into the dividend
  ctl_t                     s7_ctl;
  logic [PAY_W-1:0]         s7_pay;
  logic [NUM_W-1:0]         s7_num;
  logic [SUM_W-1:0]         s7_sum;
  logic [P_W-1:0]           s7_dividend;

  always_ff @(posedge clk) begin
    if (rst) s7_ctl <= '0;
    else     s7_ctl <= s6_ctl;
  end

  always_ff @(posedge clk) begin
    s7_pay      <= s6_pay;
    s7_num      <= s6_num;
    s7_sum      <= s6_sum;
    s7_dividend <= (P_W'(s6_p_hi) << LO_W) + P_W'(s6_p_lo);
  end

  assign ctl_out      = s7_ctl;
  assign num_out      = s7_num;
  assign divisor_out  = s7_sum;
  assign dividend_out = s7_dividend;
  assign pay_out      = s7_pay;

endmodule

@@ rtl/core/cir_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module cir_divider #(
  parameter int Q_W   = 53,
  parameter int D_W   = 33,
  parameter int PAY_W = 8,
  localparam int DVD_W = Q_W + D_W - 1
) (
  input  logic              clk,
  input  logic              rst,
  input  cir_pkg::ctl_t     ctl_in,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [D_W-1:0]    divisor,
  input  logic [PAY_W-1:0]  pay_in,
  output cir_pkg::ctl_t     ctl_out,
  output logic [Q_W-1:0]    quotient,
  output logic              rem_nz,
  output logic [PAY_W-1:0]  pay_out
);
  import cir_pkg::*;

  // Top bits of the dividend are below the divisor, so the quotient fits Q_W bits.
  // The word register shifts dividend bits out at the top and quotient bits in.
  ctl_t             st_ctl  [Q_W];
  logic [D_W-1:0]   st_rem  [Q_W];
  logic [Q_W-1:0]   st_word [Q_W];
  logic [D_W-1:0]   st_div  [Q_W];
  logic [PAY_W-1:0] st_pay  [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    ctl_t             ctl_in_k;
    logic [D_W-1:0]   rem_in, div_in;
    logic [Q_W-1:0]   word_in;
    logic [PAY_W-1:0] pay_in_k;
    logic [D_W:0]     trial, diff;
    logic             take;

    if (k == 0) begin : g_first
      assign ctl_in_k = ctl_in;
      assign rem_in   = D_W'(dividend[DVD_W-1:Q_W]);
      assign word_in  = dividend[Q_W-1:0];
      assign div_in   = divisor;
      assign pay_in_k = pay_in;
    end else begin : g_rest
      assign ctl_in_k = st_ctl[k-1];
      assign rem_in   = st_rem[k-1];
      assign word_in  = st_word[k-1];
      assign div_in   = st_div[k-1];
      assign pay_in_k = st_pay[k-1];
    end

    always_comb begin
      trial = {rem_in, word_in[Q_W-1]};
      diff  = trial - {1'b0, div_in};
      take  = (trial >= {1'b0, div_in});
    end

    always_ff @(posedge clk) begin
      if (rst) st_ctl[k] <= '0;
      else     st_ctl[k] <= ctl_in_k;
    end

    always_ff @(posedge clk) begin
      st_rem[k]  <= take ? diff[D_W-1:0] : trial[D_W-1:0];
      st_word[k] <= {word_in[Q_W-2:0], take};
      st_div[k]  <= div_in;
      st_pay[k]  <= pay_in_k;
    end
  end

  assign ctl_out  = st_ctl[Q_W-1];
  assign quotient = st_word[Q_W-1];
  assign rem_nz   = |st_rem[Q_W-1];
  assign pay_out  = st_pay[Q_W-1];

endmodule

@@ rtl/core/cir_apply.sv @@
// Back stages: impulse shares, per-axis deltas and saturated velocity update.
`timescale 1ns / 1ps

module cir_apply #(
  parameter int VW = 32,
  localparam int NUM_W = VW + cir_pkg::M_GROW + cir_pkg::ONE_E_W,
  localparam int PAY_W = 4 * VW + 2 * cir_pkg::NRM_W
) (
  input  logic              clk,
  input  logic              rst,
  input  cir_pkg::ctl_t     ctl_in,
  input  logic [NUM_W-1:0]  quot,
  input  logic              rem_nz,
  input  logic [NUM_W-1:0]  num,
  input  logic [PAY_W-1:0]  pay,
  output cir_pkg::ctl_t     ctl_out,
  output logic [VW-1:0]     new_vel_a_x,
  output logic [VW-1:0]     new_vel_a_y,
  output logic [VW-1:0]     new_vel_b_x,
  output logic [VW-1:0]     new_vel_b_y
);
  import cir_pkg::*;

  localparam int S_W   = NUM_W + 1 - FRAC_V;
  localparam int MAG_W = S_W + NRM_W;
  localparam int R_W   = MAG_W + 1 - FRAC_N;
  localparam int DL_W  = R_W + 1;
  localparam int SV_W  = DL_W + 1;

  localparam int OFF_NY  = 0;
  localparam int OFF_NX  = NRM_W;
  localparam int OFF_VBY = 2 * NRM_W;
  localparam int OFF_VBX = OFF_VBY + VW;
  localparam int OFF_VAY = OFF_VBX + VW;
  localparam int OFF_VAX = OFF_VAY + VW;

  localparam logic signed [SV_W-1:0] V_HI =
    $signed({{(SV_W - VW + 1){1'b0}}, {(VW - 1){1'b1}}});
  localparam logic signed [SV_W-1:0] V_LO = ~V_HI;

  function automatic logic [VW-1:0] sat(input logic signed [SV_W-1:0] v);
    if (v > V_HI)      return V_HI[VW-1:0];
    else if (v < V_LO) return V_LO[VW-1:0];
    else               return v[VW-1:0];
  endfunction

  // A1: B share from A share (they add to num, less one on a remainder), round to Q16.16
  ctl_t             a1_ctl;
  logic [PAY_W-1:0] a1_pay;
  logic [S_W-1:0]   a1_sa, a1_sb;
  logic [NUM_W-1:0] sb_q;
  logic [NUM_W:0]   sa_round, sb_round;

  always_comb begin
    sb_q     = num - quot - NUM_W'(rem_nz);
    sa_round = (NUM_W + 1)'(quot) + (NUM_W + 1)'(HALF_V);
    sb_round = (NUM_W + 1)'(sb_q) + (NUM_W + 1)'(HALF_V);
  end

  always_ff @(posedge clk) begin
    if (rst) a1_ctl <= '0;
    else     a1_ctl <= ctl_in;
  end

  always_ff @(posedge clk) begin
    a1_pay <= pay;
    a1_sa  <= S_W'(sa_round >> FRAC_V);
    a1_sb  <= S_W'(sb_round >> FRAC_V);
  end

  // A2: share times normal magnitude
  ctl_t               a2_ctl;
  logic [PAY_W-1:0]   a2_pay;
  logic [MAG_W-1:0]   a2_mag_ax, a2_mag_ay, a2_mag_bx, a2_mag_by;
  logic [NRM_W-1:0]   nx_abs, ny_abs;

  always_comb begin
    nx_abs = a1_pay[OFF_NX + NRM_W - 1] ? NRM_W'(-a1_pay[OFF_NX +: NRM_W])
                                        : a1_pay[OFF_NX +: NRM_W];
    ny_abs = a1_pay[OFF_NY + NRM_W - 1] ? NRM_W'(-a1_pay[OFF_NY +: NRM_W])
                                        : a1_pay[OFF_NY +: NRM_W];
  end

  always_ff @(posedge clk) begin
    if (rst) a2_ctl <= '0;
    else     a2_ctl <= a1_ctl;
  end

  always_ff @(posedge clk) begin
    a2_pay    <= a1_pay;
    a2_mag_ax <= a1_sa * nx_abs;
    a2_mag_ay <= a1_sa * ny_abs;
    a2_mag_bx <= a1_sb * nx_abs;
    a2_mag_by <= a1_sb * ny_abs;
  end

  // A3: round to Q16.16, half away from zero, sign of the normal restored
  ctl_t                     a3_ctl;
  logic [PAY_W-1:0]         a3_pay;
  logic signed [DL_W-1:0]   a3_d_ax, a3_d_ay, a3_d_bx, a3_d_by;
  logic [R_W-1:0]           r_ax, r_ay, r_bx, r_by;
  logic                     nx_neg, ny_neg;

  always_comb begin
    r_ax   = R_W'(((MAG_W + 1)'(a2_mag_ax) + (MAG_W + 1)'(HALF_N)) >> FRAC_N);
    r_ay   = R_W'(((MAG_W + 1)'(a2_mag_ay) + (MAG_W + 1)'(HALF_N)) >> FRAC_N);
    r_bx   = R_W'(((MAG_W + 1)'(a2_mag_bx) + (MAG_W + 1)'(HALF_N)) >> FRAC_N);
    r_by   = R_W'(((MAG_W + 1)'(a2_mag_by) + (MAG_W + 1)'(HALF_N)) >> FRAC_N);
    nx_neg = a2_pay[OFF_NX + NRM_W - 1];
    ny_neg = a2_pay[OFF_NY + NRM_W - 1];
  end

  always_ff @(posedge clk) begin
    if (rst) a3_ctl <= '0;
    else     a3_ctl <= a2_ctl;
  end

  always_ff @(posedge clk) begin
    a3_pay  <= a2_pay;
    a3_d_ax <= nx_neg ? -DL_W'(r_ax) : DL_W'(r_ax);
    a3_d_ay <= ny_neg ? -DL_W'(r_ay) : DL_W'(r_ay);
    a3_d_bx <= nx_neg ? -DL_W'(r_bx) : DL_W'(r_bx);
    a3_d_by <= ny_neg ? -DL_W'(r_by) : DL_W'(r_by);
  end

  // A4: A loses the delta, B gains it; pass-through unless an impulse applies
  ctl_t                    a4_ctl;
  logic [VW-1:0]           a4_va_x, a4_va_y, a4_vb_x, a4_vb_y;
  logic signed [VW-1:0]    va_x, va_y, vb_x, vb_y;
  logic signed [SV_W-1:0]  sum_ax, sum_ay, sum_bx, sum_by;
  logic                    apply_imp;

  always_comb begin
    va_x      = $signed(a3_pay[OFF_VAX +: VW]);
    va_y      = $signed(a3_pay[OFF_VAY +: VW]);
    vb_x      = $signed(a3_pay[OFF_VBX +: VW]);
    vb_y      = $signed(a3_pay[OFF_VBY +: VW]);
    sum_ax    = SV_W'(va_x) - SV_W'(a3_d_ax);
    sum_ay    = SV_W'(va_y) - SV_W'(a3_d_ay);
    sum_bx    = SV_W'(vb_x) + SV_W'(a3_d_bx);
    sum_by    = SV_W'(vb_y) + SV_W'(a3_d_by);
    apply_imp = (a3_ctl.outcome == OUTCOME_IMPULSE);
  end

  always_ff @(posedge clk) begin
    if (rst) a4_ctl <= '0;
    else     a4_ctl <= a3_ctl;
  end

  always_ff @(posedge clk) begin
    a4_va_x <= apply_imp ? sat(sum_ax) : va_x;
    a4_va_y <= apply_imp ? sat(sum_ay) : va_y;
    a4_vb_x <= apply_imp ? sat(sum_bx) : vb_x;
    a4_vb_y <= apply_imp ? sat(sum_by) : vb_y;
  end

  assign ctl_out     = a4_ctl;
  assign new_vel_a_x = a4_va_x;
  assign new_vel_a_y = a4_va_y;
  assign new_vel_b_x = a4_vb_x;
  assign new_vel_b_y = a4_vb_y;

endmodule

@@ rtl/core/collision_impulse_response.sv @@
// Top level of the 2D linear collision impulse response pipeline.
`timescale 1ns / 1ps

// Impulse response for one 2D contact per request. A request is taken on
// any rising edge with start high and busy low; busy is high only while rst
// is asserted, so the block takes one contact every cycle with no gaps. The
// result passes through 7 front stages, one stage per quotient bit of the
// mass-ratio divider (VW + 21 stages, VW being VEL_WIDTH capped at 32) and
// 4 back stages. Results come out in request order on the new_vel_* and
// outcome ports, each held for exactly one cycle and marked by done; the
// receiver cannot stall the pipeline, so it must take every result as it
// appears. Velocities are read from the low VW bits of each port and
// results are saturated to that signed range, with any upper port bits
// driven to zero.
module collision_impulse_response #(
  parameter int VEL_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [VEL_WIDTH-1:0]       vel_a_x,
  input  logic signed [VEL_WIDTH-1:0]       vel_a_y,
  input  logic signed [VEL_WIDTH-1:0]       vel_b_x,
  input  logic signed [VEL_WIDTH-1:0]       vel_b_y,
  input  logic [cir_pkg::REST_W-1:0]        restitution_a,
  input  logic [cir_pkg::REST_W-1:0]        restitution_b,
  input  logic [cir_pkg::IMASS_W-1:0]       inv_mass_a,
  input  logic [cir_pkg::IMASS_W-1:0]       inv_mass_b,
  input  logic signed [cir_pkg::NRM_W-1:0]  normal_x,
  input  logic signed [cir_pkg::NRM_W-1:0]  normal_y,
  output logic                              done,
  output logic signed [VEL_WIDTH-1:0]       new_vel_a_x,
  output logic signed [VEL_WIDTH-1:0]       new_vel_a_y,
  output logic signed [VEL_WIDTH-1:0]       new_vel_b_x,
  output logic signed [VEL_WIDTH-1:0]       new_vel_b_y,
  output logic [$bits(cir_pkg::outcome_t)-1:0] outcome
);
  import cir_pkg::*;

  // Effective velocity width.
  localparam int VW    = (VEL_WIDTH < VEL_CAP) ? VEL_WIDTH : VEL_CAP;
  // Widths of the numerator (1+e)*m, its product with inv_mass_a, and the
  // side data (four velocities and the normal) riding along.
  localparam int NUM_W = VW + M_GROW + ONE_E_W;
  localparam int P_W   = NUM_W + IMASS_W;
  localparam int PAY_W = 4 * VW + 2 * NRM_W;
  localparam int DP_W  = NUM_W + PAY_W;

  logic in_valid;

  // No backpressure anywhere: the only time a request is refused is reset.
  assign busy     = rst;
  assign in_valid = start & ~busy;

  // Front end: relative velocity along the normal, outcome decision, and
  // the dividend num * inv_mass_a for the mass split.
  ctl_t              fr_ctl;
  logic [NUM_W-1:0]  fr_num;
  logic [SUM_W-1:0]  fr_sum;
  logic [P_W-1:0]    fr_dividend;
  logic [PAY_W-1:0]  fr_pay;

  cir_front #(
    .VW (VW)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .vel_a_x       (vel_a_x[VW-1:0]),
    .vel_a_y       (vel_a_y[VW-1:0]),
    .vel_b_x       (vel_b_x[VW-1:0]),
    .vel_b_y       (vel_b_y[VW-1:0]),
    .restitution_a (restitution_a),
    .restitution_b (restitution_b),
    .inv_mass_a    (inv_mass_a),
    .inv_mass_b    (inv_mass_b),
    .normal_x      (normal_x),
    .normal_y      (normal_y),
    .ctl_out       (fr_ctl),
    .num_out       (fr_num),
    .divisor_out   (fr_sum),
    .dividend_out  (fr_dividend),
    .pay_out       (fr_pay)
  );

  // Divider: floor(num * inv_mass_a / (inv_mass_a + inv_mass_b)). Body B's
  // share is recovered from the quotient and the remainder, so one divider
  // serves both bodies. The numerator rides along for that step.
  ctl_t              dv_ctl;
  logic [NUM_W-1:0]  dv_quot;
  logic              dv_rem_nz;
  logic [DP_W-1:0]   dv_pay;

  cir_divider #(
    .Q_W   (NUM_W),
    .D_W   (SUM_W),
    .PAY_W (DP_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (fr_ctl),
    .dividend (fr_dividend),
    .divisor  (fr_sum),
    .pay_in   ({fr_num, fr_pay}),
    .ctl_out  (dv_ctl),
    .quotient (dv_quot),
    .rem_nz   (dv_rem_nz),
    .pay_out  (dv_pay)
  );

  // Back end: round the shares, scale by the normal, update and saturate.
  ctl_t           ap_ctl;
  logic [VW-1:0]  ap_va_x, ap_va_y, ap_vb_x, ap_vb_y;

  cir_apply #(
    .VW (VW)
  ) u_apply (
    .clk         (clk),
    .rst         (rst),
    .ctl_in      (dv_ctl),
    .quot        (dv_quot),
    .rem_nz      (dv_rem_nz),
    .num         (dv_pay[DP_W-1:PAY_W]),
    .pay         (dv_pay[PAY_W-1:0]),
    .ctl_out     (ap_ctl),
    .new_vel_a_x (ap_va_x),
    .new_vel_a_y (ap_va_y),
    .new_vel_b_x (ap_vb_x),
    .new_vel_b_y (ap_vb_y)
  );

  // Results are zero-extended from the effective width to the port width.
  assign done        = ap_ctl.valid;
  assign outcome     = ap_ctl.outcome;
  assign new_vel_a_x = VEL_WIDTH'(ap_va_x);
  assign new_vel_a_y = VEL_WIDTH'(ap_va_y);
  assign new_vel_b_x = VEL_WIDTH'(ap_vb_x);
  assign new_vel_b_y = VEL_WIDTH'(ap_vb_y);

endmodule

@@ rtl/core/cir_checker.sv @@
// Port-level checker for the collision impulse pipeline, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cir_checker #(
  parameter int VEL_WIDTH = 32
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic signed [VEL_WIDTH-1:0]       vel_a_x,
  input logic signed [VEL_WIDTH-1:0]       vel_a_y,
  input logic signed [VEL_WIDTH-1:0]       vel_b_x,
  input logic signed [VEL_WIDTH-1:0]       vel_b_y,
  input logic [cir_pkg::REST_W-1:0]        restitution_a,
  input logic [cir_pkg::REST_W-1:0]        restitution_b,
  input logic [cir_pkg::IMASS_W-1:0]       inv_mass_a,
  input logic [cir_pkg::IMASS_W-1:0]       inv_mass_b,
  input logic signed [cir_pkg::NRM_W-1:0]  normal_x,
  input logic signed [cir_pkg::NRM_W-1:0]  normal_y,
  input logic                              done,
  input logic signed [VEL_WIDTH-1:0]       new_vel_a_x,
  input logic signed [VEL_WIDTH-1:0]       new_vel_a_y,
  input logic signed [VEL_WIDTH-1:0]       new_vel_b_x,
  input logic signed [VEL_WIDTH-1:0]       new_vel_b_y,
  input logic [$bits(cir_pkg::outcome_t)-1:0] outcome
);
  import cir_pkg::*;

  localparam int VW  = (VEL_WIDTH < VEL_CAP) ? VEL_WIDTH : VEL_CAP;
  localparam int LAT = VW + 32;  // front 7 + divider VW+21 + back 4

  logic          accept, pass_through, is_static, no_mass;
  logic [4*VW-1:0] vin, vout;  // all four velocities, request side and result side

  assign accept       = start && !busy;
  assign pass_through = done && (outcome == OUTCOME_SEPARATING || outcome == OUTCOME_STATIC);
  assign is_static    = done && (outcome == OUTCOME_STATIC);
  assign no_mass      = (inv_mass_a == '0) && (inv_mass_b == '0);
  assign vin          = {vel_a_x[VW-1:0], vel_a_y[VW-1:0], vel_b_x[VW-1:0], vel_b_y[VW-1:0]};
  assign vout         = {new_vel_a_x[VW-1:0], new_vel_a_y[VW-1:0],
                         new_vel_b_x[VW-1:0], new_vel_b_y[VW-1:0]};

  // every request yields a result
  `CIR_ASSERT(a_req_to_done, accept |-> ##LAT done, "request produced no result")

  // no result without a request
  `CIR_ASSERT_IMPLY(a_done_has_req, done, $past(accept, LAT), "result without a request")

  // separating or static contacts return the velocities untouched
  `CIR_ASSERT_IMPLY(a_pass_through, pass_through, vout == $past(vin, LAT), "velocities altered")

  // static status only for two zero inverse masses
  `CIR_ASSERT_IMPLY(a_static_cause, is_static, $past(no_mass, LAT), "static with a moving body")

endmodule

bind collision_impulse_response cir_checker #(.VEL_WIDTH(VEL_WIDTH)) u_cir_checker (.*);

@@ tb/sv/collision_impulse_response_checker.sv @@
`timescale 1ns / 1ps
// Checker for the collision impulse block: predicts each contact response and compares in order.

module collision_impulse_response_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] vel_a_x,
  input  logic signed [31:0] vel_a_y,
  input  logic signed [31:0] vel_b_x,
  input  logic signed [31:0] vel_b_y,
  input  logic [16:0]        restitution_a,
  input  logic [16:0]        restitution_b,
  input  logic [31:0]        inv_mass_a,
  input  logic [31:0]        inv_mass_b,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic               done,
  input  logic signed [31:0] new_vel_a_x,
  input  logic signed [31:0] new_vel_a_y,
  input  logic signed [31:0] new_vel_b_x,
  input  logic signed [31:0] new_vel_b_y,
  input  logic [1:0]         outcome,
  output int                 mismatches,
  output int                 pending,
  output int                 checked,
  output int                 n_impulse,
  output int                 n_separating,
  output int                 n_static
);
  import cir_pkg::*;

  localparam longint      VEL_MAX    = 64'sh0000_0000_7FFF_FFFF;
  localparam longint      VEL_MIN    = -VEL_MAX - 64'sd1;
  localparam logic [16:0] E_ONE      = 17'h1_0000;
  localparam int          REPORT_MAX = 10;

  typedef struct packed {
    logic [31:0] va_x;
    logic [31:0] va_y;
    logic [31:0] vb_x;
    logic [31:0] vb_y;
    outcome_t    status;
  } response_t;

  response_t expected_q[$];
  int err_count = 0;
  int pend_r = 0;
  int chk_count = 0;
  int imp_count = 0;
  int sep_count = 0;
  int stat_count = 0;

  assign mismatches   = err_count;
  assign pending      = pend_r;
  assign checked      = chk_count;
  assign n_impulse    = imp_count;
  assign n_separating = sep_count;
  assign n_static     = stat_count;

  // floor(num * share / total), exact over 128 bits
  function automatic logic [63:0] mass_share(input logic [63:0] num, input logic [31:0] share,
                                             input logic [32:0] total);
    logic [127:0] prod;
    prod = {64'd0, num} * {96'd0, share};
    return 64'(prod / {95'd0, total});
  endfunction

  // impulse (Q.16) times one normal component, back to Q.16, rounded away from zero
  function automatic longint normal_delta(input logic [63:0] imp, input longint n);
    logic [63:0] mag;
    logic [63:0] r;
    mag = imp * 64'(n < 0 ? -n : n);
    r   = (mag + 64'd8192) >> 14;
    return (n < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic [31:0] sat_vel(input longint v);
    if (v > VEL_MAX) return 32'h7FFF_FFFF;
    if (v < VEL_MIN) return 32'h8000_0000;
    return 32'(v);
  endfunction

  function automatic response_t contact_response(
    input logic signed [31:0] ax, ay, bx, by,
    input logic [16:0] ea, eb,
    input logic [31:0] ia, ib,
    input logic signed [15:0] nx_in, ny_in);
    longint      vax, vay, vbx, vby, nx, ny, vn;
    logic [16:0] e;
    logic [63:0] m, num, sa, sb;
    response_t   r;
    vax = ax;
    vay = ay;
    vbx = bx;
    vby = by;
    nx  = nx_in;
    ny  = ny_in;
    vn  = (vbx - vax) * nx + (vby - vay) * ny;
    if (vn > 0) begin
      r.status = OUTCOME_SEPARATING;
    end else if (ia == 32'd0 && ib == 32'd0) begin
      r.status = OUTCOME_STATIC;
    end else begin
      r.status = OUTCOME_IMPULSE;
      e = (ea < eb) ? ea : eb;
      if (e > E_ONE) e = E_ONE;
      m   = (64'(-vn) + 64'd8192) >> 14;
      num = (64'd65536 + 64'(e)) * m;
      sa  = (mass_share(num, ia, {1'b0, ia} + {1'b0, ib}) + 64'd32768) >> 16;
      sb  = (mass_share(num, ib, {1'b0, ia} + {1'b0, ib}) + 64'd32768) >> 16;
      vax = vax - normal_delta(sa, nx);
      vay = vay - normal_delta(sa, ny);
      vbx = vbx + normal_delta(sb, nx);
      vby = vby + normal_delta(sb, ny);
    end
    r.va_x = sat_vel(vax);
    r.va_y = sat_vel(vay);
    r.vb_x = sat_vel(vbx);
    r.vb_y = sat_vel(vby);
    return r;
  endfunction

  always @(posedge clk) begin
    response_t want;
    logic      bad;
    if (!rst) begin
      if (done) begin
        if (expected_q.size() == 0) begin
          err_count++;
          if (err_count <= REPORT_MAX)
            $display("%0t: result with no request pending: a=(%h,%h) b=(%h,%h) outcome %0d",
                     $realtime, new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y, outcome);
        end else begin
          want = expected_q.pop_front();
          chk_count++;
          case (want.status)
            OUTCOME_IMPULSE:    imp_count++;
            OUTCOME_SEPARATING: sep_count++;
            default:            stat_count++;
          endcase
          bad = (new_vel_a_x != want.va_x) || (new_vel_a_y != want.va_y) ||
                (new_vel_b_x != want.vb_x) || (new_vel_b_y != want.vb_y) ||
                (outcome != want.status);
          if (bad) begin
            err_count++;
            if (err_count <= REPORT_MAX)
              $display({"%0t: result %0d differs\n",
                        "  a_x exp %h got %h\n  a_y exp %h got %h\n",
                        "  b_x exp %h got %h\n  b_y exp %h got %h\n",
                        "  outcome exp %0d got %0d"},
                       $realtime, chk_count,
                       want.va_x, new_vel_a_x, want.va_y, new_vel_a_y,
                       want.vb_x, new_vel_b_x, want.vb_y, new_vel_b_y,
                       want.status, outcome);
          end
        end
      end
      if (start && !busy)
        expected_q = {expected_q, contact_response(vel_a_x, vel_a_y, vel_b_x, vel_b_y,
                                                   restitution_a, restitution_b,
                                                   inv_mass_a, inv_mass_b,
                                                   normal_x, normal_y)};
      pend_r <= expected_q.size();
    end
  end

endmodule

@@ tb/sv/collision_impulse_response_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the collision impulse block: request stimulus, reset, timeout and verdict.

module collision_impulse_response_tb;

  // The block takes one request per cycle once out of reset; the drain tail
  // below watches for stray results once every request has been answered.
  localparam int N_RANDOM   = 850;
  localparam int QUIET_TAIL = 100;  // last requests go back to back
  localparam int DRAIN_WAIT = 80;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] vel_a_x = '0;
  logic signed [31:0] vel_a_y = '0;
  logic signed [31:0] vel_b_x = '0;
  logic signed [31:0] vel_b_y = '0;
  logic [16:0]        restitution_a = '0;
  logic [16:0]        restitution_b = '0;
  logic [31:0]        inv_mass_a = '0;
  logic [31:0]        inv_mass_b = '0;
  logic signed [15:0] normal_x = '0;
  logic signed [15:0] normal_y = '0;
  logic               done;
  logic signed [31:0] new_vel_a_x;
  logic signed [31:0] new_vel_a_y;
  logic signed [31:0] new_vel_b_x;
  logic signed [31:0] new_vel_b_y;
  logic [1:0]         outcome;

  int mismatches, pending, checked, n_impulse, n_separating, n_static;
  int n_sent = 0;

  always #1 clk = ~clk;

  collision_impulse_response #(
    .VEL_WIDTH(32)
  ) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .vel_a_x(vel_a_x), .vel_a_y(vel_a_y), .vel_b_x(vel_b_x), .vel_b_y(vel_b_y),
    .restitution_a(restitution_a), .restitution_b(restitution_b),
    .inv_mass_a(inv_mass_a), .inv_mass_b(inv_mass_b),
    .normal_x(normal_x), .normal_y(normal_y),
    .done(done),
    .new_vel_a_x(new_vel_a_x), .new_vel_a_y(new_vel_a_y),
    .new_vel_b_x(new_vel_b_x), .new_vel_b_y(new_vel_b_y),
    .outcome(outcome)
  );

  collision_impulse_response_checker u_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .vel_a_x(vel_a_x), .vel_a_y(vel_a_y), .vel_b_x(vel_b_x), .vel_b_y(vel_b_y),
    .restitution_a(restitution_a), .restitution_b(restitution_b),
    .inv_mass_a(inv_mass_a), .inv_mass_b(inv_mass_b),
    .normal_x(normal_x), .normal_y(normal_y),
    .done(done),
    .new_vel_a_x(new_vel_a_x), .new_vel_a_y(new_vel_a_y),
    .new_vel_b_x(new_vel_b_x), .new_vel_b_y(new_vel_b_y),
    .outcome(outcome),
    .mismatches(mismatches), .pending(pending), .checked(checked),
    .n_impulse(n_impulse), .n_separating(n_separating), .n_static(n_static)
  );

  // Put one request on the ports and hold it until an edge takes it
  // (start high, busy low). Returns in the step of that edge, so the next
  // request can follow in the very next cycle.
  task automatic send_contact(input logic [31:0] ax, ay, bx, by,
                              input logic [16:0] ea, eb,
                              input logic [31:0] ia, ib,
                              input logic [15:0] nx, ny);
    vel_a_x       <= ax;
    vel_a_y       <= ay;
    vel_b_x       <= bx;
    vel_b_y       <= by;
    restitution_a <= ea;
    restitution_b <= eb;
    inv_mass_a    <= ia;
    inv_mass_b    <= ib;
    normal_x      <= nx;
    normal_y      <= ny;
    start         <= 1'b1;
    do @(posedge clk); while (busy);
    n_sent++;
  endtask

  // Sender gap: drop start and idle for the requested gap.
  task automatic hold_off(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop sending until every outstanding request has been answered.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Velocity mix: mostly a few units in Q16.16, some full-range, some rails.
  function automatic logic [31:0] pick_velocity();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
      1, 2:    return $urandom();
      default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  // Inverse mass: static, light/heavy bodies in a normal band, full range.
  function automatic logic [31:0] pick_inv_mass();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom();
      default: return $urandom_range(1, 32'h0004_0000);
    endcase
  endfunction

  // Restitution: mostly in [0, 1.0], a few exactly at the ends and some above 1.0
  function automatic logic [16:0] pick_restitution();
    case ($urandom_range(0, 15))
      0:       return 17'h0_0000;
      1:       return 17'h1_0000;
      2:       return 17'($urandom_range(32'h1_0001, 32'h1_FFFF));
      default: return 17'($urandom_range(0, 32'h1_0000));
    endcase
  endfunction

  // Normal packed as {x, y}: axis-aligned, diagonal, zero or arbitrary (non-unit).
  function automatic logic [31:0] pick_normal();
    logic [15:0] s, t;
    s = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
    t = $urandom_range(0, 1) ? 16'h2D41 : 16'hD2BF;  // +/- 1/sqrt(2)
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1) ? {s, 16'h0000} : {16'h0000, s};
      1:       return {t, $urandom_range(0, 1) ? t : 16'(16'h0000 - t)};
      2:       return 32'h0000_0000;
      default: return {16'($urandom_range(0, 32768) - 16384),
                       16'($urandom_range(0, 32768) - 16384)};
    endcase
  endfunction

  initial begin
    logic [31:0] ax, ay, bx, by, ia, ib, nrm;
    logic [16:0] ea, eb;
    longint      vn;
    int          i;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // ---- directed requests ----
    // all zero: not separating, both static
    send_contact(0, 0, 0, 0, 17'h0_0000, 17'h0_0000, 0, 0, 16'h0000, 16'h0000);
    // B moving away along +x: separating
    send_contact(0, 0, 32'h0001_0000, 0, 17'h1_0000, 17'h1_0000,
                 32'h0001_0000, 32'h0001_0000, 16'h4000, 16'h0000);
    // head-on, equal masses, elastic
    send_contact(32'h0001_0000, 0, 32'hFFFF_0000, 0, 17'h1_0000, 17'h1_0000,
                 32'h0001_0000, 32'h0001_0000, 16'h4000, 16'h0000);
    // same velocity: zero normal speed, impulse path with zero deltas
    send_contact(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000,
                 17'h0_8000, 17'h0_8000, 32'h0001_0000, 32'h0001_0000,
                 16'h4000, 16'h0000);
    // sliding purely tangentially
    send_contact(0, 32'h0005_0000, 0, 0, 17'h0_8000, 17'h0_4000,
                 32'h0002_0000, 32'h0000_8000, 16'h4000, 16'h0000);
    // A static, B approaching
    send_contact(0, 0, 32'hFFFD_0000, 0, 17'h0_C000, 17'h0_4000,
                 32'h0000_0000, 32'h0001_0000, 16'h4000, 16'h0000);
    // B static, A approaching
    send_contact(32'h0003_0000, 0, 0, 0, 17'h0_C000, 17'h1_0000,
                 32'h0001_0000, 32'h0000_0000, 16'h4000, 16'h0000);
    // both static while approaching
    send_contact(32'h0001_0000, 0, 32'hFFFF_0000, 0, 17'h1_0000, 17'h1_0000,
                 32'h0000_0000, 32'h0000_0000, 16'h4000, 16'h0000);
    // rails on x, lightest bodies: outputs saturate
    send_contact(32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 17'h1_0000, 17'h1_0000,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h4000, 16'h0000);
    // rails on y against a negative normal
    send_contact(0, 32'h8000_0000, 0, 32'h7FFF_FFFF, 17'h1_0000, 17'h1_0000,
                 32'hFFFF_FFFF, 32'h0000_0001, 16'h0000, 16'hC000);
    // restitution above 1.0 on both: clamped
    send_contact(32'h0002_0000, 32'h0001_0000, 0, 0, 17'h1_FFFF, 17'h1_FFFF,
                 32'h0001_0000, 32'h0003_0000, 16'h4000, 16'h0000);
    // one above 1.0, one zero: minimum wins
    send_contact(32'h0002_0000, 0, 0, 0, 17'h1_FFFF, 17'h0_0000,
                 32'h0001_0000, 32'h0001_0000, 16'h4000, 16'h0000);
    // fully inelastic
    send_contact(0, 32'h0004_0000, 0, 32'hFFFC_0000, 17'h0_0000, 17'h0_0000,
                 32'h0000_4000, 32'h0004_0000, 16'h0000, 16'h4000);
    // non-unit normal (length sqrt 2)
    send_contact(32'h0001_8000, 32'h0001_0000, 0, 0, 17'h0_8000, 17'h1_0000,
                 32'h0001_0000, 32'h0002_0000, 16'h4000, 16'h4000);
    // zero normal: zero normal speed
    send_contact(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 0, 17'h0_8000, 17'h0_8000,
                 32'h0001_0000, 32'h0001_0000, 16'h0000, 16'h0000);
    // all-ones normal and A velocity
    send_contact(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 17'h1_0000, 17'h0_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    // extreme mass ratio
    send_contact(32'h0010_0000, 0, 32'hFFF0_0000, 0, 17'h0_FFFF, 17'h0_FFFF,
                 32'h0000_0001, 32'hFFFF_FFFF, 16'h4000, 16'h0000);
    // diagonal unit normal
    send_contact(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000,
                 17'h0_CCCD, 17'h0_B333, 32'h0001_0000, 32'h0000_8000, 16'h2D41, 16'h2D41);
    // every velocity at the negative rail: zero relative velocity
    send_contact(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 17'h1_0000, 17'h1_0000, 32'h0001_0000, 32'h0001_0000, 16'h4000, 16'hC000);
    // largest separating speed
    send_contact(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 17'h1_0000, 17'h1_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h4000, 16'h4000);

    // sender waits out every outstanding result once
    wait_drained();

    // ---- random requests ----
    for (i = 0; i < N_RANDOM; i++) begin
      ax  = pick_velocity();
      ay  = pick_velocity();
      bx  = pick_velocity();
      by  = pick_velocity();
      ea  = pick_restitution();
      eb  = pick_restitution();
      ia  = pick_inv_mass();
      ib  = pick_inv_mass();
      nrm = pick_normal();
      if ($urandom_range(0, 19) == 0) begin
        ia = '0;
        ib = '0;
      end
      // Most contacts should approach, otherwise the impulse path is
      // starved: flip the normal on three quarters of the separating ones.
      vn = (longint'($signed(bx)) - longint'($signed(ax))) * longint'($signed(nrm[31:16])) +
           (longint'($signed(by)) - longint'($signed(ay))) * longint'($signed(nrm[15:0]));
      if (vn > 0 && $urandom_range(0, 3) != 0)
        nrm = {16'(16'h0000 - nrm[31:16]), 16'(16'h0000 - nrm[15:0])};

      send_contact(ax, ay, bx, by, ea, eb, ia, ib, nrm[31:16], nrm[15:0]);

      if (i == N_RANDOM / 2)
        wait_drained();
      else if (i < N_RANDOM - QUIET_TAIL && $urandom_range(0, 7) == 0)
        hold_off($urandom_range(1, 18));
    end

    // let the pipeline empty, then watch a little longer for stray results
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d contact requests, checked %0d results:", n_sent, checked);
    $display("  %0d impulse, %0d separating, %0d both static.",
             n_impulse, n_separating, n_static);
    if (mismatches == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog set well beyond the slowest legal run; reaching it is reported as a mismatch.
  initial begin
    #200000;
    $display("Mismatches found");
    $finish;
  end

endmodule
